// File: rtl/core/lls_pkg.sv
// ----------------------------------------------------------------------------
// Least-loaded slot allocator package
// Shared sizes, codes and the state update bundle of the slot allocator.
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int NUM_GROUPS      = 5;
  localparam int SLOTS_PER_GROUP = 5;
  localparam int MASK_W          = 5;
  localparam int GROUP_W         = 3;
  localparam int SLOT_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int LOAD_W          = $clog2(SLOTS_PER_GROUP + 1);

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;

  typedef logic [NUM_GROUPS-1:0][SLOTS_PER_GROUP-1:0] occ_t;
  typedef logic [NUM_GROUPS-1:0][LOAD_W-1:0]          load_t;

  // One-hot group and slot selects for the bitmap and load update.
  typedef struct packed {
    logic [NUM_GROUPS-1:0]      alloc_grp;
    logic [SLOTS_PER_GROUP-1:0] alloc_slot;
    logic [NUM_GROUPS-1:0]      rel_grp;
    logic [SLOTS_PER_GROUP-1:0] rel_slot;
  } lls_upd_t;

endpackage

// File: rtl/core/lls_if.sv
// ----------------------------------------------------------------------------
// Slot allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lls_req_if;
  import lls_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [GROUP_W-1:0] release_group;
  logic [SLOT_W-1:0]  release_slot;

  modport source (output valid, req_type, release_group, release_slot, input ready);
  modport sink   (input valid, req_type, release_group, release_slot, output ready);
endinterface

interface lls_rsp_if;
  import lls_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [GROUP_W-1:0]  granted_group;
  logic [SLOT_W-1:0]   granted_slot;

  modport source (output valid, status, granted_group, granted_slot, input ready);
  modport sink   (input valid, status, granted_group, granted_slot, output ready);
endinterface

// File: rtl/core/least_loaded_slot_allocator.sv
// Requests are registered at the input and results in the result register.
// Throughput: one request per cycle while rsp.ready holds; the input register,
// the combinational decision through the group bitmaps and counters, and the
// result register overlap; a response stall backs up into the input register.
// Reset: rst is synchronous; all slots become free, all loads zero, mask 5'b11111.
// ----------------------------------------------------------------------------
// Least-loaded slot allocator
// Two-level allocator: least-loaded enabled group, then its first free slot; also frees released slots.
// ----------------------------------------------------------------------------
module least_loaded_slot_allocator (
  input  logic                       clk,
  input  logic                       rst,
  lls_req_if.sink                    req,
  lls_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [lls_pkg::MASK_W-1:0] cfg_wdata
);
  import lls_pkg::*;

  logic [MASK_W-1:0]   mask;
  logic                in_valid;
  logic                in_req_type;
  logic [GROUP_W-1:0]  in_group;
  logic [SLOT_W-1:0]   in_slot;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [GROUP_W-1:0]  out_group;
  logic [SLOT_W-1:0]   out_slot;
  logic                advance;

  logic [STATUS_W-1:0] pick_status;
  logic [GROUP_W-1:0]  pick_group;
  logic [SLOT_W-1:0]   pick_slot;
  lls_upd_t            pick_upd;
  lls_upd_t            state_upd;
  occ_t                occ;
  load_t               load;

  // The held request is resolved when the result register is free or draining.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign state_upd = advance ? pick_upd : '0;

  lls_pick u_pick (
    .mask          (mask),
    .occ           (occ),
    .load          (load),
    .req_type      (in_req_type),
    .release_group (in_group),
    .release_slot  (in_slot),
    .status        (pick_status),
    .granted_group (pick_group),
    .granted_slot  (pick_slot),
    .upd           (pick_upd)
  );

  lls_state u_state (
    .clk  (clk),
    .rst  (rst),
    .upd  (state_upd),
    .occ  (occ),
    .load (load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '1;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask <= cfg_wdata;
      end
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type <= req.req_type;
      in_group    <= req.release_group;
      in_slot     <= req.release_slot;
    end
    if (advance) begin
      out_status <= pick_status;
      out_group  <= pick_group;
      out_slot   <= pick_slot;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_group = out_group;
  assign rsp.granted_slot  = out_slot;

endmodule

// File: rtl/core/lls_pick.sv
// ----------------------------------------------------------------------------
// Slot allocator decision logic
// Chooses the least-loaded enabled group and its first free slot, or checks
// a release against the bitmap, and forms the result and the state update.
// ----------------------------------------------------------------------------
module lls_pick (
  input  logic [lls_pkg::MASK_W-1:0]   mask,
  input  lls_pkg::occ_t                occ,
  input  lls_pkg::load_t               load,
  input  logic                         req_type,
  input  logic [lls_pkg::GROUP_W-1:0]  release_group,
  input  logic [lls_pkg::SLOT_W-1:0]   release_slot,
  output logic [lls_pkg::STATUS_W-1:0] status,
  output logic [lls_pkg::GROUP_W-1:0]  granted_group,
  output logic [lls_pkg::SLOT_W-1:0]   granted_slot,
  output lls_pkg::lls_upd_t            upd
);
  import lls_pkg::*;

  logic [LOAD_W-1:0]          lowest;
  logic [GROUP_W-1:0]         best;
  logic                       found;
  logic [NUM_GROUPS-1:0]      best_oh;
  occ_t                       first_free;
  logic [SLOTS_PER_GROUP-1:0] alloc_slot_oh;
  logic [SLOT_W-1:0]          alloc_slot_idx;
  logic [SLOTS_PER_GROUP-1:0] rel_slot_oh;
  logic [NUM_GROUPS-1:0]      rel_hit;

  // Least-loaded search; a group at capacity never beats the start value.
  always_comb begin
    lowest = LOAD_W'(SLOTS_PER_GROUP);
    best   = '0;
    found  = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g < MASK_W && mask[g] && load[g] < lowest) begin
        lowest = load[g];
        best   = GROUP_W'(g);
        found  = 1'b1;
      end
    end
  end

  // Lowest free slot of every group, then the one of the chosen group.
  always_comb begin
    alloc_slot_oh  = '0;
    alloc_slot_idx = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      first_free[g] = ~occ[g] & (occ[g] + SLOTS_PER_GROUP'(1));
      best_oh[g]    = found && (best == GROUP_W'(g));
      if (best_oh[g]) begin
        alloc_slot_oh = alloc_slot_oh | first_free[g];
      end
    end
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      if (alloc_slot_oh[s]) begin
        alloc_slot_idx = alloc_slot_idx | SLOT_W'(s);
      end
    end
  end

  // An out-of-range group or slot decodes to no select and so never hits.
  always_comb begin
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      rel_slot_oh[s] = (release_slot == SLOT_W'(s));
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      rel_hit[g] = (release_group == GROUP_W'(g)) && ((occ[g] & rel_slot_oh) != '0);
    end
  end

  always_comb begin
    status        = STATUS_OK;
    granted_group = '0;
    granted_slot  = '0;
    upd           = '0;
    if (req_type == REQ_ALLOC) begin
      if (alloc_slot_oh != '0) begin
        granted_group  = best;
        granted_slot   = alloc_slot_idx;
        upd.alloc_grp  = best_oh;
        upd.alloc_slot = alloc_slot_oh;
      end else begin
        status = STATUS_FULL;
      end
    end else begin
      if (rel_hit != '0) begin
        upd.rel_grp  = rel_hit;
        upd.rel_slot = rel_slot_oh;
      end else begin
        status = STATUS_NOT_HELD;
      end
    end
  end

endmodule

// File: rtl/core/lls_state.sv
// ----------------------------------------------------------------------------
// Slot allocator state
// Occupancy bitmaps and load counters of all groups.
// ----------------------------------------------------------------------------
module lls_state (
  input  logic              clk,
  input  logic              rst,
  input  lls_pkg::lls_upd_t upd,
  output lls_pkg::occ_t     occ,
  output lls_pkg::load_t    load
);
  import lls_pkg::*;

  occ_t  occ_next;
  load_t load_next;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      occ_next[g]  = occ[g];
      load_next[g] = load[g];
      if (upd.alloc_grp[g]) begin
        occ_next[g]  = occ[g] | upd.alloc_slot;
        load_next[g] = load[g] + LOAD_W'(1);
      end
      if (upd.rel_grp[g]) begin
        occ_next[g] = occ[g] & ~upd.rel_slot;
        if (load[g] != '0) begin
          load_next[g] = load[g] - LOAD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      load <= '0;
    end else begin
      occ  <= occ_next;
      load <= load_next;
    end
  end

endmodule

// File: sim/tb_least_loaded_slot_allocator.sv
// ----------------------------------------------------------------------------
// Least-loaded slot allocator testbench
// Runs a table of directed requests and then random allocate and release
// traffic under changing group masks and handshake pressure. Every response
// transaction is checked against a typed result or the built-in bitmap model.
// ----------------------------------------------------------------------------
module tb_least_loaded_slot_allocator;
  import lls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 36;
  localparam int SEG_ITEMS   = 40;

  typedef struct packed {
    logic               req_type;
    logic [GROUP_W-1:0] grp;
    logic [SLOT_W-1:0]  slot;
  } slot_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GROUP_W-1:0]  grp;
    logic [SLOT_W-1:0]   slot;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_MASK} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    slot_req_t         req;
    logic [MASK_W-1:0] mask;
    logic              typed;
    grant_t            grant;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  lls_req_if req_ch ();
  lls_rsp_if rsp_ch ();

  // Model of the allocator state.
  logic [SLOTS_PER_GROUP-1:0] held_map [NUM_GROUPS];
  logic [LOAD_W-1:0]          group_count [NUM_GROUPS];
  logic [MASK_W-1:0]          mask_shadow;

  grant_t    pending_grants [$];
  plan_row_t plan_q [$];
  int        errors      = 0;
  int        cycle_count = 0;
  int        idle_pct    = 0;
  int        stall_pct   = 0;

  least_loaded_slot_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("least_loaded_slot_allocator test failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // Applies one request to the model and returns the response it must produce.
  function automatic grant_t predict_grant(input slot_req_t r);
    grant_t res;
    int     best;
    int     lowest;
    res = '{STATUS_OK, '0, '0};
    if (r.req_type == REQ_ALLOC) begin
      best   = -1;
      lowest = SLOTS_PER_GROUP;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        if (g < MASK_W && mask_shadow[g] && group_count[g] < lowest) begin
          lowest = group_count[g];
          best   = g;
        end
      end
      res.status = STATUS_FULL;
      if (best >= 0) begin
        for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
          if (res.status == STATUS_FULL && !held_map[best][s]) begin
            held_map[best][s] = 1'b1;
            group_count[best] = group_count[best] + 1'b1;
            res = '{STATUS_OK, best[GROUP_W-1:0], s[SLOT_W-1:0]};
          end
        end
      end
    end else if (r.grp < NUM_GROUPS && r.slot < SLOTS_PER_GROUP &&
                 held_map[r.grp][r.slot]) begin
      held_map[r.grp][r.slot] = 1'b0;
      if (group_count[r.grp] != 0) group_count[r.grp] = group_count[r.grp] - 1'b1;
    end else begin
      res.status = STATUS_NOT_HELD;
    end
    return res;
  endfunction

  // Releases mostly target held slots so that the groups drain as well as fill.
  function automatic slot_req_t draw_request(input int alloc_pct);
    slot_req_t r;
    int        held_list [$];
    int        pick;
    r.req_type = ($urandom_range(99) < alloc_pct) ? REQ_ALLOC : REQ_RELEASE;
    r.grp      = GROUP_W'($urandom_range(7));
    r.slot     = SLOT_W'($urandom_range(7));
    if (r.req_type == REQ_RELEASE && $urandom_range(99) < 80) begin
      for (int g = 0; g < NUM_GROUPS; g++)
        for (int s = 0; s < SLOTS_PER_GROUP; s++)
          if (held_map[g][s]) held_list.push_back(g * 8 + s);
      if (held_list.size() != 0) begin
        pick   = held_list[$urandom_range(held_list.size() - 1)];
        r.grp  = GROUP_W'(pick / 8);
        r.slot = SLOT_W'(pick % 8);
      end
    end
    return r;
  endfunction

  task automatic plan(input row_kind_e kind, input logic rt, input int g, input int s,
                      input int m, input logic typed, input logic [STATUS_W-1:0] st,
                      input int eg, input int es);
    plan_q.push_back('{kind, '{rt, g[GROUP_W-1:0], s[SLOT_W-1:0]}, m[MASK_W-1:0], typed,
                       '{st, eg[GROUP_W-1:0], es[SLOT_W-1:0]}});
  endtask

  task automatic send_req(input slot_req_t r, input logic typed, input grant_t typed_grant);
    grant_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= r.req_type;
    req_ch.release_group <= r.grp;
    req_ch.release_slot  <= r.slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_grant(r);
    pending_grants.push_back(typed ? typed_grant : predicted);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    settle();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mask_shadow = m;
  endtask

  // Response side: random stalls and the check of every response transaction.
  initial begin
    grant_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_grants.size() == 0) begin
          report("response with no request outstanding");
        end else begin
          want = pending_grants.pop_front();
          if (rsp_ch.status !== want.status)
            report($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
          if (rsp_ch.granted_group !== want.grp)
            report($sformatf("granted_group got %0d want %0d", rsp_ch.granted_group,
                             want.grp));
          if (rsp_ch.granted_slot !== want.slot)
            report($sformatf("granted_slot got %0d want %0d", rsp_ch.granted_slot,
                             want.slot));
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int alloc_pct;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_ALLOC;
    req_ch.release_group <= '0;
    req_ch.release_slot  <= '0;
    mask_shadow = '1;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      held_map[g]    = '0;
      group_count[g] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Release of a free slot and of indexes that name no slot.
    plan(ROW_REQ,  REQ_RELEASE, 0, 0, 0, 1'b1, STATUS_NOT_HELD, 0, 0);
    plan(ROW_REQ,  REQ_RELEASE, 7, 7, 0, 1'b1, STATUS_NOT_HELD, 0, 0);
    plan(ROW_REQ,  REQ_RELEASE, 5, 0, 0, 1'b1, STATUS_NOT_HELD, 0, 0);
    plan(ROW_REQ,  REQ_RELEASE, 0, 5, 0, 1'b1, STATUS_NOT_HELD, 0, 0);
    // Ties between equal loads go to the lowest group.
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b1, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   7, 7, 0, 1'b1, STATUS_OK, 1, 0);
    plan(ROW_REQ,  REQ_ALLOC,   3, 5, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b1, STATUS_OK, 4, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_RELEASE, 0, 0, 0, 1'b1, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    // With every group disabled, held slots stay and can still be released.
    plan(ROW_MASK, REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b1, STATUS_FULL, 0, 0);
    plan(ROW_REQ,  REQ_RELEASE, 4, 0, 0, 1'b1, STATUS_OK, 0, 0);
    // Only the top group enabled: fill it and run out.
    plan(ROW_MASK, REQ_ALLOC,   0, 0, 16, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b1, STATUS_OK, 4, 4);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b1, STATUS_FULL, 0, 0);
    plan(ROW_REQ,  REQ_RELEASE, 4, 4, 0, 1'b1, STATUS_OK, 0, 0);
    plan(ROW_MASK, REQ_ALLOC,   0, 0, 31, 1'b0, STATUS_OK, 0, 0);
    plan(ROW_REQ,  REQ_ALLOC,   0, 0, 0, 1'b0, STATUS_OK, 0, 0);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_MASK) write_mask(plan_q[i].mask);
      else send_req(plan_q[i].req, plan_q[i].typed, plan_q[i].grant);
    end

    // Each segment draws a fill or drain mix at random and writes a fresh mask.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / (SEGMENTS / 4))
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (seg % 5 == 0) write_mask('1);
      else if (seg % 7 == 3) write_mask('0);
      else write_mask(MASK_W'($urandom_range(31)));
      case ($urandom_range(2))
        0:       alloc_pct = 15;
        1:       alloc_pct = 50;
        default: alloc_pct = 90;
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) send_req(draw_request(alloc_pct), 1'b0, '0);
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("least_loaded_slot_allocator test passed");
    else $display("least_loaded_slot_allocator test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/lls_pkg.sv
rtl/core/lls_if.sv
rtl/core/lls_pick.sv
rtl/core/lls_state.sv
rtl/core/least_loaded_slot_allocator.sv
sim/tb_least_loaded_slot_allocator.sv
